/* hw/rtl/acsi_pkg.sv */
// Shared types, constants and the opcode decoder of the ACSI disk command unit.
// Used by every module under hw/rtl except acsi_queue; depends on nothing.
package acsi_pkg;

    // Queue depth between the parts and on the result side
    localparam int unsigned ACSI_QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ID     = 2'd0;
    localparam logic [1:0] CFG_DRIVE_PRESENT = 2'd1;
    localparam logic [1:0] CFG_DISK_SECTORS  = 2'd2;

    localparam int unsigned CFG_DATA_W = 25;

    // Bus constants
    localparam logic [7:0] MODE_STATUS_READ = 8'h8a;
    localparam logic [7:0] FIRST_BYTE_MASK  = 8'h1f;
    localparam logic [7:0] SENSE_BAD_OPCODE = 8'h20;
    localparam logic [7:0] STATUS_GOOD      = 8'h00;
    localparam logic [7:0] STATUS_ERROR     = 8'h02;

    // Byte counter codes
    localparam logic [2:0] CNT_FIRST = 3'd0;
    localparam logic [2:0] CNT_LAST  = 3'd5;
    localparam logic [2:0] CNT_READY = 3'd7;

    // Command opcodes
    localparam logic [7:0] OPC_READY   = 8'h00;
    localparam logic [7:0] OPC_SENSE   = 8'h03;
    localparam logic [7:0] OPC_FORMAT  = 8'h04;
    localparam logic [7:0] OPC_READ    = 8'h08;
    localparam logic [7:0] OPC_WRITE   = 8'h0a;
    localparam logic [7:0] OPC_SEEK    = 8'h0b;
    localparam logic [7:0] OPC_INQUIRY = 8'h12;
    localparam logic [7:0] OPC_MODESEL = 8'h15;

    typedef enum logic [3:0] {
        OP_READY   = 4'd0,
        OP_SENSE   = 4'd1,
        OP_FORMAT  = 4'd2,
        OP_READ    = 4'd3,
        OP_WRITE   = 4'd4,
        OP_SEEK    = 4'd5,
        OP_INQUIRY = 4'd6,
        OP_MODESEL = 4'd7,
        OP_INVALID = 4'd8
    } acsi_op_t;

    // One host bus access
    typedef struct packed {
        logic       command;
        logic       line_a1;
        logic [7:0] write_byte;
        logic [7:0] mode_word;
    } acsi_in_t;

    // One result per access
    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_asserted;
        logic        command_done;
        logic [3:0]  operation;
        logic [23:0] start_sector;
        logic [7:0]  transfer_count;
        logic [7:0]  status_value;
        logic [7:0]  sense_code;
    } acsi_out_t;

    // Classified access passed from front to back
    typedef struct packed {
        logic       is_read;
        logic       status_sel;
        logic       store_en;
        logic       opens;
        logic [7:0] data;
    } acsi_cls_t;

    function automatic acsi_op_t acsi_decode(input logic [7:0] opc);
        acsi_op_t op;
        case (opc)
            OPC_READY:   op = OP_READY;
            OPC_SENSE:   op = OP_SENSE;
            OPC_FORMAT:  op = OP_FORMAT;
            OPC_READ:    op = OP_READ;
            OPC_WRITE:   op = OP_WRITE;
            OPC_SEEK:    op = OP_SEEK;
            OPC_INQUIRY: op = OP_INQUIRY;
            OPC_MODESEL: op = OP_MODESEL;
            default:     op = OP_INVALID;
        endcase
        return op;
    endfunction

endpackage

/* hw/rtl/acsi_disk_command_unit.sv */
// ACSI disk command unit: takes one host bus access per clock cycle unless full, each giving
// one result. An accepted access is classified in the front part, waits in a queue of
// QUEUE_DEPTH entries, and is carried out by the back part, whose result enters the result
// queue; the result becomes visible after passing through both queues. The back part's update
// of byte counter, status and interrupt sets the throughput of one access per cycle while
// neither queue stalls; both queues let either side stall without losing items. Configuration
// writes are always ready. Depends on acsi_pkg, acsi_front, acsi_queue and acsi_back.
module acsi_disk_command_unit
    import acsi_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = ACSI_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  acsi_in_t              access,
    output logic                  empty,
    input  logic                  pop,
    output acsi_out_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned ClsW = $bits(acsi_cls_t);
    localparam int unsigned OutW = $bits(acsi_out_t);

    logic      cfg_we;
    acsi_cls_t front_cls, back_cls;
    logic      mid_empty, out_full, exec;
    acsi_out_t back_result;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    acsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .access    (access),
        .cls       (front_cls)
    );

    acsi_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ClsW)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cls),
        .full  (full),
        .pop   (exec),
        .rdata (back_cls),
        .empty (mid_empty)
    );

    // Advance the back part when an item waits and the result has room
    assign exec = !mid_empty && !out_full;

    acsi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .exec      (exec),
        .cls       (back_cls),
        .result    (back_result)
    );

    acsi_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (OutW)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (exec),
        .wdata (back_result),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

/* hw/rtl/acsi_queue.sv */
// Small first-in first-out queue of flat words, used between front and back
// and on the result side. Depends on nothing but its parameters.
module acsi_queue #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             wr_en, rd_en;

    // Qualify the handshakes
    assign full  = (count_reg == CntW'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign rdata = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("queue count did not follow a lone write");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && !wr_en |=> count_reg == $past(count_reg) - CntW'(1))
        else $error("queue count did not follow a lone read");
`endif

endmodule

/* hw/rtl/acsi_front.sv */
// Front part: holds the bus id and drive presence and classifies each host access.
// Depends on acsi_pkg.
module acsi_front
    import acsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  acsi_in_t              access,
    output acsi_cls_t             cls
);

    logic [2:0] device_id_reg;
    logic       drive_present_reg;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg     <= '0;
            drive_present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_ID:     device_id_reg     <= cfg_data[2:0];
                CFG_DRIVE_PRESENT: drive_present_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Classify the access
    always_comb
    begin
        cls.is_read    = access.command;
        cls.status_sel = (access.mode_word == MODE_STATUS_READ);
        cls.store_en   = !access.command && drive_present_reg;
        cls.opens      = !access.line_a1 && (access.write_byte[7:5] == device_id_reg);
        cls.data       = access.write_byte;
    end

endmodule

/* hw/rtl/acsi_back.sv */
// Back part: command byte collection, opcode decode, status, sense and interrupt state.
// Depends on acsi_pkg.
module acsi_back
    import acsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  exec,
    input  acsi_cls_t             cls,
    output acsi_out_t             result
);

    logic [24:0] disk_sectors_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  cmd_reg [5];
    logic [7:0]  status_reg, status_next;
    logic [7:0]  error_reg, error_next;
    logic        irq_reg, irq_next;

    logic        ready, open_cmd, store, last;
    logic [2:0]  slot;
    logic [7:0]  byte_val;
    logic [23:0] sector;
    logic [7:0]  count;
    logic [24:0] end_sector;
    acsi_op_t    op;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_sectors_reg <= '0;
        end
        else if (cfg_we && (cfg_index == CFG_DISK_SECTORS))
        begin
            disk_sectors_reg <= cfg_data;
        end
    end

    // Decode the collected command
    always_comb
    begin
        ready      = (cnt_reg == CNT_READY);
        open_cmd   = cls.store_en && cls.opens && ready;
        slot       = open_cmd ? CNT_FIRST : cnt_reg;
        store      = cls.store_en && (open_cmd || !ready);
        last       = store && (slot == CNT_LAST);
        byte_val   = open_cmd ? (cls.data & FIRST_BYTE_MASK) : cls.data;
        sector     = {cmd_reg[1], cmd_reg[2], cmd_reg[3]};
        count      = cmd_reg[4];
        op         = acsi_decode(cmd_reg[0]);
        end_sector = {1'b0, sector} + {17'd0, count};
    end

    // Work out the next state
    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = status_reg;
        error_next  = error_reg;
        irq_next    = irq_reg;
        if (cls.is_read)
        begin
            irq_next = 1'b0;
        end
        else if (store)
        begin
            irq_next = 1'b1;
            cnt_next = last ? CNT_READY : slot + 3'd1;
        end
        if (last)
        begin
            status_next = STATUS_GOOD;
            if (op == OP_READ)
            begin
                if ((count != '0) && (end_sector > disk_sectors_reg))
                begin
                    status_next = STATUS_ERROR;
                end
            end
            else if (op == OP_INVALID)
            begin
                status_next = STATUS_ERROR;
                error_next  = SENSE_BAD_OPCODE;
            end
        end
    end

    // Build the result
    always_comb
    begin
        result.read_data      = (cls.is_read && cls.status_sel) ? status_reg : 8'd0;
        result.irq_asserted   = irq_next;
        result.command_done   = last;
        result.operation      = last ? op : OP_READY;
        result.start_sector   = last ? sector : 24'd0;
        result.transfer_count = last ? count : 8'd0;
        result.status_value   = status_next;
        result.sense_code     = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= CNT_READY;
            status_reg <= STATUS_GOOD;
            error_reg  <= '0;
            irq_reg    <= 1'b0;
        end
        else if (exec)
        begin
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
            error_reg  <= error_next;
            irq_reg    <= irq_next;
        end
    end

    // Hold command bytes; the sixth byte is never needed
    always_ff @(posedge clk)
    begin
        if (exec && store && !last)
        begin
            cmd_reg[slot] <= byte_val;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST || cnt_reg == CNT_READY)
        else $error("byte counter left its legal range");

    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        exec && last |=> cnt_reg == CNT_READY)
        else $error("unit not ready after a complete command");

    a_read_clears_irq: assert property (@(posedge clk) disable iff (!rst_n)
        exec && cls.is_read |=> !irq_reg)
        else $error("read did not clear the interrupt");

    a_status_codes: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg == STATUS_GOOD || status_reg == STATUS_ERROR)
        else $error("status holds an unknown code");
`endif

endmodule

/* bench/tb.sv */
// Self-checking bench for acsi_disk_command_unit: drives host bus accesses and register
// writes, predicts every result item from its own copy of the command state.
// Depends on acsi_pkg and the RTL under hw/rtl.
module tb;
    import acsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CDB_LEN      = 6;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_ITEMS  = 240;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    acsi_in_t              access = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    acsi_out_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Bench copy of the unit's registers and command state
    logic [2:0]            dev_id_q;
    logic                  drive_on_q;
    logic [CFG_DATA_W-1:0] disk_size_q;
    logic [2:0]            cdb_pos;
    logic [7:0]            cdb [CDB_LEN];
    logic [7:0]            status_q;
    logic [7:0]            sense_q;
    logic                  irq_q;

    acsi_out_t pending_replies [$];
    acsi_out_t reply_due;

    // Run bookkeeping
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned accesses_sent = 0;
    int unsigned replies_seen = 0;
    int unsigned commands_done = 0;
    int unsigned reads_past_end = 0;
    int unsigned bad_opcodes = 0;
    int unsigned settings_used = 0;
    int unsigned hold_left = 0;
    int unsigned pop_gap = 0;
    bit          quiet = 1'b0;

    acsi_disk_command_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .access    (access),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Work out the result item of one access and advance the bench state
    function automatic acsi_out_t bus_access_outcome(input acsi_in_t a);
        acsi_out_t  r;
        logic [7:0] b;
        logic       raise;
        logic [23:0] sec;
        logic [25:0] reach;
        acsi_op_t   op;
        r = '0;
        raise = 1'b0;
        b = a.write_byte;
        if (a.command)
        begin
            if (a.mode_word == MODE_STATUS_READ)
                r.read_data = status_q;
            irq_q = 1'b0;
        end
        else if (drive_on_q)
        begin
            // open a command only from the ready state, with a matching id and A1 low
            if (!a.line_a1 && b[7:5] == dev_id_q && cdb_pos == CNT_READY)
            begin
                cdb_pos = CNT_FIRST;
                b = b & FIRST_BYTE_MASK;
            end
            if (cdb_pos <= CNT_LAST)
            begin
                cdb[cdb_pos] = b;
                cdb_pos++;
                raise = 1'b1;
            end
            if (cdb_pos == 3'(CDB_LEN))
            begin
                sec = {cdb[1], cdb[2], cdb[3]};
                case (cdb[0])
                    OPC_READY:   op = OP_READY;
                    OPC_SENSE:   op = OP_SENSE;
                    OPC_FORMAT:  op = OP_FORMAT;
                    OPC_READ:    op = OP_READ;
                    OPC_WRITE:   op = OP_WRITE;
                    OPC_SEEK:    op = OP_SEEK;
                    OPC_INQUIRY: op = OP_INQUIRY;
                    OPC_MODESEL: op = OP_MODESEL;
                    default:     op = OP_INVALID;
                endcase
                status_q = STATUS_GOOD;
                reach = 26'(sec) + 26'(cdb[4]);
                if (op == OP_READ && cdb[4] != 8'd0 && reach > 26'(disk_size_q))
                begin
                    status_q = STATUS_ERROR;
                    reads_past_end++;
                end
                else if (op == OP_INVALID)
                begin
                    status_q = STATUS_ERROR;
                    sense_q = SENSE_BAD_OPCODE;
                    bad_opcodes++;
                end
                cdb_pos = CNT_READY;
                commands_done++;
                r.command_done = 1'b1;
                r.operation = op;
                r.start_sector = sec;
                r.transfer_count = cdb[4];
            end
            if (raise)
                irq_q = 1'b1;
        end
        r.irq_asserted = irq_q;
        r.status_value = status_q;
        r.sense_code = sense_q;
        return r;
    endfunction

    function automatic logic [7:0] pick_mode();
        if ($urandom_range(0, 2) == 0)
            return MODE_STATUS_READ;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: stall in random bursts, or for a long hold when asked
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else if (pop_gap > 0)
        begin
            pop <= 1'b0;
            pop_gap--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            pop <= 1'b0;
            pop_gap = $urandom_range(0, 3);
        end
        else
            pop <= 1'b1;
    end

    // Compare each accepted result item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result item with no prediction waiting");
                mismatches++;
            end
            else
            begin
                reply_due = pending_replies.pop_front();
                check_field("read_data", 32'(reply_due.read_data), 32'(result.read_data));
                check_field("irq_asserted", 32'(reply_due.irq_asserted),
                            32'(result.irq_asserted));
                check_field("command_done", 32'(reply_due.command_done),
                            32'(result.command_done));
                check_field("operation", 32'(reply_due.operation), 32'(result.operation));
                check_field("start_sector", 32'(reply_due.start_sector),
                            32'(result.start_sector));
                check_field("transfer_count", 32'(reply_due.transfer_count),
                            32'(result.transfer_count));
                check_field("status_value", 32'(reply_due.status_value),
                            32'(result.status_value));
                check_field("sense_code", 32'(reply_due.sense_code), 32'(result.sense_code));
                replies_seen++;
            end
        end
    end

    // Offer one access, with an optional idle burst first, and hold it until taken
    task automatic offer_access(input logic rd, input logic a1, input logic [7:0] wb,
                                input logic [7:0] md);
        acsi_in_t a;
        int unsigned gap;
        a.command = rd;
        a.line_a1 = a1;
        a.write_byte = wb;
        a.mode_word = md;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        access <= a;
        do
            @(posedge clk);
        while (full);
        pending_replies.push_back(bus_access_outcome(a));
        accesses_sent++;
    endtask

    // Drop push and wait until every predicted item has come back
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEVICE_ID:     dev_id_q = val[2:0];
            CFG_DRIVE_PRESENT: drive_on_q = val[0];
            CFG_DISK_SECTORS:  disk_size_q = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] id, input logic present,
                              input logic [CFG_DATA_W-1:0] sectors);
        write_reg(CFG_DEVICE_ID, CFG_DATA_W'(id));
        write_reg(CFG_DRIVE_PRESENT, CFG_DATA_W'(present));
        write_reg(CFG_DISK_SECTORS, sectors);
        settings_used++;
    endtask

    // Six command bytes: opcode with device id, sector high to low, count, control
    task automatic send_command(input logic [4:0] opc, input logic [23:0] sec,
                                input logic [7:0] cnt, input int unsigned stop_at);
        logic [7:0] bytes [CDB_LEN];
        bytes[0] = {dev_id_q, opc};
        bytes[1] = sec[23:16];
        bytes[2] = sec[15:8];
        bytes[3] = sec[7:0];
        bytes[4] = cnt;
        bytes[5] = 8'($urandom_range(0, 255));
        for (int i = 0; i < stop_at; i++)
        begin
            // slip an occasional read between command bytes
            if ($urandom_range(0, 9) == 0)
                offer_access(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             pick_mode());
            offer_access(1'b0, (i == 0) ? 1'b0 : 1'($urandom_range(0, 1)), bytes[i],
                         8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_command();
        logic [4:0]  opc;
        logic [23:0] sec;
        logic [7:0]  cnt;
        logic [7:0]  known [8];
        int unsigned pick;
        known = '{OPC_READY, OPC_SENSE, OPC_FORMAT, OPC_READ,
                  OPC_WRITE, OPC_SEEK, OPC_INQUIRY, OPC_MODESEL};
        pick = $urandom_range(0, 11);
        if (pick < 8)
            opc = known[pick][4:0];
        else if (pick < 10)
            opc = OPC_READ[4:0];
        else
            opc = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 3))
            0: sec = 24'($urandom);
            1: sec = (disk_size_q > 300) ? 24'(disk_size_q - $urandom_range(0, 300))
                                         : 24'($urandom_range(0, 300));
            2: sec = 24'($urandom_range(0, 1000));
            default: sec = $urandom_range(0, 1) ? 24'hffffff : 24'h000000;
        endcase
        if ($urandom_range(0, 3) == 0)
            cnt = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else
            cnt = 8'($urandom_range(0, 255));
        send_command(opc, sec, cnt, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5)
                                                                  : CDB_LEN);
    endtask

    // Mostly well-formed commands, the rest stray writes and reads
    task automatic run_mix(input int unsigned n);
        int unsigned start;
        start = accesses_sent;
        while (accesses_sent - start < n)
        begin
            if ($urandom_range(0, 9) < 7)
                send_random_command();
            else
                offer_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)), pick_mode());
        end
    endtask

    task automatic test_no_drive();
        // reset values: id 0, no drive, so an opening byte is ignored
        offer_access(1'b0, 1'b0, {3'd0, OPC_READ[4:0]}, 8'h00);
        offer_access(1'b1, 1'b1, 8'hff, MODE_STATUS_READ);
        wait_idle();
    endtask

    task automatic test_directed_cases();
        set_config(3'd5, 1'b1, CFG_DATA_W'(1000));
        // stray writes: wrong id, then right id with A1 high
        offer_access(1'b0, 1'b0, {3'd4, OPC_READ[4:0]}, 8'hff);
        offer_access(1'b0, 1'b1, {3'd5, OPC_READ[4:0]}, 8'h00);
        // read beyond the disk at the top sector with the largest count
        send_command(OPC_READ[4:0], 24'hffffff, 8'hff, CDB_LEN);
        offer_access(1'b1, 1'b0, 8'h00, MODE_STATUS_READ);
        offer_access(1'b1, 1'b0, 8'h00, 8'h00);
        // unknown opcode 0x1f with every sector and count bit set
        send_command(5'h1f, 24'hffffff, 8'hff, CDB_LEN);
        // zero-count read never fails
        send_command(OPC_READ[4:0], 24'hffffff, 8'h00, CDB_LEN);
        offer_access(1'b1, 1'b1, 8'hff, MODE_STATUS_READ);
        wait_idle();
    endtask

    task automatic test_random_phases();
        set_config(3'd0, 1'b1, CFG_DATA_W'(0));
        run_mix(PHASE_ITEMS);
        wait_idle();
        set_config(3'd7, 1'b1, CFG_DATA_W'(24'hffffff) + 1'b1);
        run_mix(PHASE_ITEMS);
        wait_idle();
        set_config(3'($urandom_range(0, 7)), 1'b0, CFG_DATA_W'($urandom_range(0, 1 << 24)));
        run_mix(60);
        wait_idle();
        set_config(3'($urandom_range(0, 7)), 1'b1, CFG_DATA_W'($urandom_range(0, 2000)));
        run_mix(PHASE_ITEMS);
        wait_idle();
        set_config(3'd3, 1'b1, CFG_DATA_W'($urandom_range(0, 1 << 24)));
        run_mix(PHASE_ITEMS);
        wait_idle();
        set_config(3'($urandom_range(0, 7)), 1'b1, CFG_DATA_W'($urandom_range(0, 1 << 24)));
        run_mix(PHASE_ITEMS);
        wait_idle();
    endtask

    task automatic test_backpressure();
        // hold the result side while accesses keep coming, so the unit fills up
        @(posedge clk);
        hold_left = 250;
        run_mix(60);
        wait_idle();
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        set_config(3'($urandom_range(0, 7)), 1'b1, CFG_DATA_W'($urandom_range(0, 1 << 24)));
        run_mix(150);
        wait_idle();
    endtask

    initial
    begin
        dev_id_q = '0;
        drive_on_q = 1'b0;
        disk_size_q = '0;
        cdb_pos = CNT_READY;
        for (int i = 0; i < CDB_LEN; i++)
            cdb[i] = '0;
        status_q = '0;
        sense_q = '0;
        irq_q = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_no_drive();
        test_directed_cases();
        test_random_phases();
        test_backpressure();
        test_quiet_tail();

        $display("Ran %0d accesses, %0d results checked, %0d commands completed,",
                 accesses_sent, replies_seen, commands_done);
        $display("%0d reads past the disk end, %0d bad opcodes, %0d register settings",
                 reads_past_end, bad_opcodes, settings_used);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/acsi_pkg.sv
hw/rtl/acsi_queue.sv
hw/rtl/acsi_front.sv
hw/rtl/acsi_back.sv
hw/rtl/acsi_disk_command_unit.sv
bench/tb.sv
